// File: rtl/core/assert_macros.svh
// Assertion shorthands shared by the RTL. Each expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/rfidchk_pkg.sv
`default_nettype none
package rfidchk_pkg;

  localparam int DATA_CHARS = 10;
  localparam int CNT_W      = $clog2(DATA_CHARS);
  localparam int CHAR_W     = 8;
  localparam int NIB_W      = 4;
  localparam int CODE_W     = 40;

  localparam logic [CHAR_W-1:0] START_BYTE_RESET = 8'h02;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_START_BYTE = 1'b0;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_DATA,
    PH_SUM
  } phase_t;

  typedef enum logic [2:0] {
    OP_START,
    OP_DATA_HI,
    OP_DATA_LO,
    OP_SUM_HI,
    OP_SUM_LO
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic [NIB_W-1:0] nib;
    logic             bad;
  } cmd_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } queue_status_t;

  // Returns {bad, nibble}. Anything outside '0'..'9' and 'A'..'F' is nibble zero.
  function automatic logic [NIB_W:0] hex_nibble(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] d;
    d = '0;
    if (c inside {[8'd48:8'd57]}) begin
      d = c - 8'd48;
      return {1'b0, d[NIB_W-1:0]};
    end else if (c inside {[8'd65:8'd70]}) begin
      d = c - 8'd55;
      return {1'b0, d[NIB_W-1:0]};
    end
    return {1'b1, {NIB_W{1'b0}}};
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/rfid_ascii_hex_frame_checker.sv
// Accepts one received byte per cycle; rx_ready drops only while the command queue is full.
// A result is registered when the back end pops the closing checksum request from the queue,
// so res_valid rises from the register that takes that pop, and no stall can come between them.
// Back-to-back frames sustain one byte per cycle as long as res_ready keeps up.
// Synchronous active-high reset returns to hunting, empties the queue, drops res_valid
// and sets start_byte to 0x02.
`default_nettype none
`include "assert_macros.svh"
module rfid_ascii_hex_frame_checker (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [rfidchk_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [rfidchk_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rfidchk_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                    pready,
  input  wire logic                               rx_valid,
  output logic                                    rx_ready,
  input  wire logic [rfidchk_pkg::CHAR_W-1:0]     rx_byte,
  output logic                                    res_valid,
  input  wire logic                               res_ready,
  output logic [rfidchk_pkg::CODE_W-1:0]          tag_code,
  output logic [rfidchk_pkg::CHAR_W-1:0]          computed_xor,
  output logic [rfidchk_pkg::CHAR_W-1:0]          received_sum,
  output logic                                    sum_ok,
  output logic                                    bad_char
);
  import rfidchk_pkg::*;

  logic [CHAR_W-1:0] start_byte;
  logic [0:0]        reg_index;
  logic              push, q_pop;
  cmd_t              push_cmd, q_cmd;
  queue_status_t     q_status;

  assign pready    = 1'b1;
  assign reg_index = paddr[APB_ADDR_W-1 -: 1];
  assign prdata    = (reg_index == REG_START_BYTE)
                     ? {{(APB_DATA_W - CHAR_W){1'b0}}, start_byte} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_BYTE_RESET;
    end else if (psel && penable && pwrite && pready && reg_index == REG_START_BYTE) begin
      start_byte <= pwdata[CHAR_W-1:0];
    end
  end

  rfidchk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_ready   (rx_ready),
    .rx_byte    (rx_byte),
    .start_byte (start_byte),
    .q_status   (q_status),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  rfidchk_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .status   (q_status)
  );

  rfidchk_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (!q_status.empty),
    .cmd          (q_cmd),
    .pop          (q_pop),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .tag_code     (tag_code),
    .computed_xor (computed_xor),
    .received_sum (received_sum),
    .sum_ok       (sum_ok),
    .bad_char     (bad_char)
  );

  `ASSERT_ALWAYS(a_queue_bound, q_status.count <= QCNT_W'(QUEUE_DEPTH), "queue overfilled")
  `ASSERT_IMPLIES(a_ready_tracks_queue, q_status.full, !rx_ready, "ready while queue full")
  `ASSERT_NEXT(a_last_sum_loads, q_pop && q_cmd.op == OP_SUM_LO, res_valid, "result lost")
  `ASSERT_IMPLIES(a_sum_ok_match, res_valid, sum_ok == (computed_xor == received_sum),
                  "pass flag disagrees with checksum")

endmodule
`default_nettype wire

// File: rtl/core/rfidchk_front.sv
`default_nettype none
module rfidchk_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           rx_valid,
  output logic                                rx_ready,
  input  wire logic [rfidchk_pkg::CHAR_W-1:0] rx_byte,
  input  wire logic [rfidchk_pkg::CHAR_W-1:0] start_byte,
  input  wire rfidchk_pkg::queue_status_t     q_status,
  output logic                                push,
  output rfidchk_pkg::cmd_t                   push_cmd
);
  import rfidchk_pkg::*;

  phase_t           phase, phase_next;
  logic [CNT_W-1:0] char_count, char_count_next;
  logic             accept;
  logic [NIB_W:0]   conv;

  assign rx_ready = !q_status.full;
  assign accept   = rx_valid && rx_ready;
  assign conv     = hex_nibble(rx_byte);

  always_comb begin
    phase_next      = phase;
    char_count_next = char_count;
    case (phase)
      PH_HUNT: begin
        if (accept && rx_byte == start_byte) begin
          phase_next      = PH_DATA;
          char_count_next = '0;
        end
      end
      PH_DATA: begin
        if (accept) begin
          if (char_count == CNT_W'(DATA_CHARS - 1)) begin
            phase_next      = PH_SUM;
            char_count_next = '0;
          end else begin
            char_count_next = char_count + CNT_W'(1);
          end
        end
      end
      PH_SUM: begin
        if (accept) begin
          if (char_count == '0) begin
            char_count_next = CNT_W'(1);
          end else begin
            phase_next      = PH_HUNT;
            char_count_next = '0;
          end
        end
      end
      default: begin
        phase_next      = PH_HUNT;
        char_count_next = '0;
      end
    endcase
  end

  // Bytes seen while hunting that do not open a frame are dropped here.
  always_comb begin
    push         = 1'b0;
    push_cmd.op  = OP_START;
    push_cmd.nib = conv[NIB_W-1:0];
    push_cmd.bad = conv[NIB_W];
    case (phase)
      PH_HUNT: begin
        push        = accept && rx_byte == start_byte;
        push_cmd.op = OP_START;
      end
      PH_DATA: begin
        push        = accept;
        push_cmd.op = char_count[0] ? OP_DATA_LO : OP_DATA_HI;
      end
      PH_SUM: begin
        push        = accept;
        push_cmd.op = char_count[0] ? OP_SUM_LO : OP_SUM_HI;
      end
      default: begin
        push        = 1'b0;
        push_cmd.op = OP_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      char_count <= '0;
    end else begin
      phase      <= phase_next;
      char_count <= char_count_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rfidchk_cmd_queue.sv
`default_nettype none
module rfidchk_cmd_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire rfidchk_pkg::cmd_t          push_cmd,
  input  wire logic                       pop,
  output rfidchk_pkg::cmd_t               pop_cmd,
  output rfidchk_pkg::queue_status_t      status
);
  import rfidchk_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign status.count = count;
  assign status.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_cmd      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/rfidchk_back.sv
`default_nettype none
module rfidchk_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cmd_valid,
  input  wire rfidchk_pkg::cmd_t              cmd,
  output logic                                pop,
  output logic                                res_valid,
  input  wire logic                           res_ready,
  output logic [rfidchk_pkg::CODE_W-1:0]      tag_code,
  output logic [rfidchk_pkg::CHAR_W-1:0]      computed_xor,
  output logic [rfidchk_pkg::CHAR_W-1:0]      received_sum,
  output logic                                sum_ok,
  output logic                                bad_char
);
  import rfidchk_pkg::*;

  logic [CODE_W-1:0] code_shift;
  logic [CHAR_W-1:0] xor_acc;
  logic [NIB_W-1:0]  high_nibble;
  logic [NIB_W-1:0]  sum_high;
  logic              bad_seen;
  logic [CHAR_W-1:0] sum_byte;

  // Only the closing checksum character needs the output register free.
  assign pop = cmd_valid && (cmd.op != OP_SUM_LO || !res_valid || res_ready);
  assign sum_byte = {sum_high, cmd.nib};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop && cmd.op == OP_SUM_LO) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      case (cmd.op)
        OP_START: begin
          code_shift  <= '0;
          xor_acc     <= '0;
          high_nibble <= '0;
          sum_high    <= '0;
          bad_seen    <= 1'b0;
        end
        OP_DATA_HI: begin
          code_shift  <= {code_shift[CODE_W-NIB_W-1:0], cmd.nib};
          high_nibble <= cmd.nib;
          bad_seen    <= bad_seen | cmd.bad;
        end
        OP_DATA_LO: begin
          code_shift <= {code_shift[CODE_W-NIB_W-1:0], cmd.nib};
          xor_acc    <= xor_acc ^ {high_nibble, cmd.nib};
          bad_seen   <= bad_seen | cmd.bad;
        end
        OP_SUM_HI: begin
          sum_high <= cmd.nib;
          bad_seen <= bad_seen | cmd.bad;
        end
        OP_SUM_LO: begin
          tag_code     <= code_shift;
          computed_xor <= xor_acc;
          received_sum <= sum_byte;
          sum_ok       <= xor_acc == sum_byte;
          bad_char     <= bad_seen | cmd.bad;
        end
        default: begin
          bad_seen <= bad_seen;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rfidchk_pkg::*;

  localparam logic [APB_ADDR_W-1:0] START_BYTE_ADDR = APB_ADDR_W'(4 * REG_START_BYTE);
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR      = APB_ADDR_W'(4);
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_CYCLES  = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int ROUND_BYTES   = 90;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [CHAR_W-1:0] xsum;
    logic [CHAR_W-1:0] rsum;
    logic              ok;
    logic              bad;
  } tag_result_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  rx_valid;
  logic                  rx_ready;
  logic [CHAR_W-1:0]     rx_byte;
  logic                  res_valid;
  logic                  res_ready;
  logic [CODE_W-1:0]     tag_code;
  logic [CHAR_W-1:0]     computed_xor;
  logic [CHAR_W-1:0]     received_sum;
  logic                  sum_ok;
  logic                  bad_char;

  // Frame tracker state, mirroring the block's view of the byte stream.
  phase_t            fr_phase;
  int                fr_count;
  logic [CODE_W-1:0] fr_code;
  logic [CHAR_W-1:0] fr_xor;
  logic [NIB_W-1:0]  fr_high;
  logic [CHAR_W-1:0] fr_sum;
  logic              fr_bad;
  logic [CHAR_W-1:0] cfg_start;

  tag_result_t pending_tags[$];
  int          errors;
  int          bytes_taken;
  bit          quiet;

  rfid_ascii_hex_frame_checker u_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .rx_valid     (rx_valid),
    .rx_ready     (rx_ready),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .tag_code     (tag_code),
    .computed_xor (computed_xor),
    .received_sum (received_sum),
    .sum_ok       (sum_ok),
    .bad_char     (bad_char)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit rand_gap();
    return !quiet && ($urandom_range(99) < 11);
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(input logic [NIB_W-1:0] n);
    if (n < 10) begin
      return 8'h30 + CHAR_W'(n);
    end
    return 8'h41 + CHAR_W'(n) - 8'd10;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic track_frame_byte(input logic [CHAR_W-1:0] c);
    logic [NIB_W-1:0] nib;
    tag_result_t      r;
    if (fr_phase == PH_HUNT) begin
      if (c == cfg_start) begin
        fr_phase = PH_DATA;
        fr_count = 0;
        fr_code  = '0;
        fr_xor   = '0;
        fr_high  = '0;
        fr_sum   = '0;
        fr_bad   = 1'b0;
        bytes_taken++;
      end
    end else begin
      bytes_taken++;
      if (c >= 8'h30 && c <= 8'h39) begin
        nib = c[3:0];
      end else if (c >= 8'h41 && c <= 8'h46) begin
        nib = c[3:0] + 4'd9;
      end else begin
        nib    = '0;
        fr_bad = 1'b1;
      end
      if (fr_phase == PH_DATA) begin
        fr_code = {fr_code[CODE_W-NIB_W-1:0], nib};
        if (fr_count % 2 == 1) begin
          fr_xor = fr_xor ^ {fr_high, nib};
        end else begin
          fr_high = nib;
        end
        if (fr_count + 1 >= DATA_CHARS) begin
          fr_phase = PH_SUM;
          fr_count = 0;
        end else begin
          fr_count++;
        end
      end else begin
        fr_sum = {fr_sum[NIB_W-1:0], nib};
        if (fr_count == 0) begin
          fr_count = 1;
        end else begin
          r.code = fr_code;
          r.xsum = fr_xor;
          r.rsum = fr_sum;
          r.ok   = (fr_xor == fr_sum);
          r.bad  = fr_bad;
          pending_tags.push_back(r);
          fr_phase = PH_HUNT;
          fr_count = 0;
        end
      end
    end
  endtask

  // Valid stays up between back-to-back requests; it only drops for a gap.
  task automatic send_byte(input logic [CHAR_W-1:0] b);
    while (rand_gap()) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!rx_ready) @(posedge clk);
    track_frame_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i]);
    end
  endtask

  task automatic send_frame(input bit allow_bad, input bit good_sum);
    logic [NIB_W-1:0]  nib;
    logic [NIB_W-1:0]  hi;
    logic [CHAR_W-1:0] x;
    logic [CHAR_W-1:0] c;
    x  = '0;
    hi = '0;
    send_byte(cfg_start);
    for (int i = 0; i < DATA_CHARS; i++) begin
      nib = NIB_W'($urandom);
      if (allow_bad && $urandom_range(99) < 8) begin
        c = CHAR_W'($urandom_range(255));
      end else begin
        c = hex_char(nib);
      end
      if (i % 2 == 1) begin
        x = x ^ {hi, nib};
      end else begin
        hi = nib;
      end
      send_byte(c);
    end
    if (!good_sum) begin
      x = CHAR_W'($urandom_range(255));
    end
    send_byte(hex_char(x[7:4]));
    send_byte(hex_char(x[3:0]));
  endtask

  task automatic apb_access(input bit wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (wr && addr == START_BYTE_ADDR) begin
      cfg_start = wdata[CHAR_W-1:0];
    end
    @(posedge clk);
  endtask

  // Waits for every result, then lets any queued bytes drain before a register access.
  task automatic settle_idle();
    rx_valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_start_reg();
    logic [APB_DATA_W-1:0] v;
    apb_access(1'b0, START_BYTE_ADDR, '0, v);
    check_field("start_byte", 64'(cfg_start), 64'(v[CHAR_W-1:0]));
  endtask

  task automatic reprogram_start(input logic [CHAR_W-1:0] value);
    logic [APB_DATA_W-1:0] unused;
    settle_idle();
    apb_access(1'b1, START_BYTE_ADDR, APB_DATA_W'(value), unused);
    check_start_reg();
  endtask

  task automatic test_register_access();
    logic [APB_DATA_W-1:0] unused;
    check_start_reg();
    // A write to an address with no register behind it must change nothing.
    apb_access(1'b1, SPARE_ADDR, 32'h55, unused);
    check_start_reg();
  endtask

  task automatic test_directed_frames();
    // Bytes other than the start byte are dropped while hunting.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_text("0");
    // Colon, at sign, lowercase, an embedded start byte, 0xFF and G are all non-hex.
    send_byte(cfg_start);
    send_text("09AF:@a");
    send_byte(cfg_start);
    send_byte(8'hFF);
    send_text("G10");
    // Largest tag code with a matching checksum.
    send_byte(cfg_start);
    send_text("FFFFFFFFFFFF");
  endtask

  task automatic test_start_change_mid_frame();
    send_byte(cfg_start);
    send_text("ABCDE");
    reprogram_start(8'h41);
    // The open frame runs on, so the new start byte is just a data character here.
    send_text("12A4500");
    send_byte(8'h02);
    send_frame(1'b0, 1'b1);
    send_frame(1'b0, 1'b0);
  endtask

  task automatic run_random_round(input logic [CHAR_W-1:0] start, input bit no_gaps);
    int goal;
    int pick;
    reprogram_start(start);
    quiet = no_gaps;
    goal  = bytes_taken + ROUND_BYTES;
    while (bytes_taken < goal) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(1'b1, $urandom_range(99) < 60);
        repeat ($urandom_range(2)) send_byte(CHAR_W'($urandom_range(255)));
      end else if (pick < 85) begin
        send_byte(CHAR_W'($urandom_range(255)));
      end else begin
        send_byte(cfg_start);
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(1)) begin
            send_byte(hex_char(NIB_W'($urandom)));
          end else begin
            send_byte(CHAR_W'($urandom_range(255)));
          end
        end
      end
    end
    quiet = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_round(8'h00, 1'b0);
    run_random_round(8'hFF, 1'b1);
    run_random_round(CHAR_W'($urandom_range(255)), 1'b0);
    run_random_round(START_BYTE_RESET, 1'b0);
  endtask

  initial begin : result_check
    tag_result_t want;
    res_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && res_ready) begin
        if (pending_tags.size() == 0) begin
          $error("tag result with no request waiting for it");
          errors++;
        end else begin
          want = pending_tags.pop_front();
          check_field("tag_code", 64'(want.code), 64'(tag_code));
          check_field("computed_xor", 64'(want.xsum), 64'(computed_xor));
          check_field("received_sum", 64'(want.rsum), 64'(received_sum));
          check_field("sum_ok", 64'(want.ok), 64'(sum_ok));
          check_field("bad_char", 64'(want.bad), 64'(bad_char));
        end
      end
      res_ready <= !rand_gap();
    end
  end

  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((rx_valid && rx_ready) || (res_valid && res_ready) || (psel && penable)) begin
        stall = 0;
      end else begin
        stall++;
      end
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    rx_valid <= 1'b0;
    rx_byte  <= '0;
    errors      = 0;
    bytes_taken = 0;
    quiet       = 1'b0;
    cfg_start   = START_BYTE_RESET;
    fr_phase    = PH_HUNT;
    fr_count    = 0;
    fr_code     = '0;
    fr_xor      = '0;
    fr_high     = '0;
    fr_sum      = '0;
    fr_bad      = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_access();
    test_directed_frames();
    test_start_change_mid_frame();
    test_random_traffic();

    rx_valid <= 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/rfidchk_pkg.sv
rtl/core/rfidchk_front.sv
rtl/core/rfidchk_cmd_queue.sv
rtl/core/rfidchk_back.sv
rtl/core/rfid_ascii_hex_frame_checker.sv
bench/tb_top.sv
